>>> sv/tolerance_pair_matcher_core_assert.svh
// Assertion macros for the tolerance pair matcher.
`ifndef TOLERANCE_PAIR_MATCHER_CORE_ASSERT_SVH
`define TOLERANCE_PAIR_MATCHER_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define TPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check of an implication.
`define TPM_ASSERT_IMP(lbl, ante, cons, msg) \
    `TPM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/tpm_pkg.sv
// Package: shared constants for the tolerance pair matcher.
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;
    localparam int OPERATION_W = 2;
    localparam int VALUE_W     = 8;
    localparam int TOL_W       = 8;
    localparam int PAIR_W      = 8;

    localparam int MAX_ITEMS_DEF  = 128;
    localparam int VALUE_BITS_DEF = 8;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

    localparam logic [OPERATION_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_COMPUTE = 2'd2;
endpackage
`default_nettype wire

>>> sv/tpm_if.sv
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface tpm_item_if;
    logic                             valid;
    logic                             ready;
    logic [tpm_pkg::OPERATION_W-1:0]  operation;
    logic [tpm_pkg::VALUE_W-1:0]      value;
    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface tpm_result_if;
    logic                        valid;
    logic                        ready;
    logic [tpm_pkg::PAIR_W-1:0]  pair_count;
    logic                        overflow;
    modport source (output valid, output pair_count, output overflow, input ready);
    modport sink   (input valid, input pair_count, input overflow, output ready);
endinterface

interface tpm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tpm_pkg::TOL_W-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/tpm_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tpm_ram #(
    parameter int DEPTH = tpm_pkg::MAX_ITEMS_DEF,
    parameter int WIDTH = tpm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/tolerance_pair_matcher_core.sv
// Top level: tolerance pair matcher with in-memory sort and two-pointer walk.
`timescale 1ns / 1ps
`default_nettype none
// Load items (operation 0 for list A, 1 for list B) are written straight
// into the list's RAM at its fill count; a load into a full list is
// dropped and raises the overflow flag. A compute item (operation 2) first
// insertion-sorts list A and then list B in place, each in its own
// single-port-read RAM with a registered read: every key is read, then
// compared with the elements before it one at a time, each larger one
// being shifted up a slot, and written where it lands. Each step of the
// two-pointer walk then reads both heads and compares them. The result goes
// to an output register; while it waits to be taken, load items are still
// accepted, and a following compute holds only its final step until the
// register frees. Operation 3 is consumed and does nothing. The tolerance
// register is written through the configuration channel, which is always
// ready; write it only while the block is idle.
module tolerance_pair_matcher_core #(
    parameter int MAX_ITEMS  = tpm_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = tpm_pkg::VALUE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tpm_item_if.sink    items,
    tpm_result_if.source results,
    tpm_cfg_if.sink     cfg
);
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int DW    = (VALUE_BITS > tpm_pkg::TOL_W) ? VALUE_BITS : tpm_pkg::TOL_W;
    localparam int IW    = (VALUE_BITS > tpm_pkg::VALUE_W) ? VALUE_BITS : tpm_pkg::VALUE_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_KEY_RD  = 4'd1;
    localparam logic [3:0] S_KEY_WT  = 4'd2;
    localparam logic [3:0] S_CMP_RD  = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_PUT     = 4'd5;
    localparam logic [3:0] S_M_RD    = 4'd6;
    localparam logic [3:0] S_M_CMP   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [3:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]           cnt_b_reg, cnt_b_next;
    logic                       drop_reg, drop_next;
    logic [tpm_pkg::TOL_W-1:0]  tol_reg;
    logic                       sel_reg, sel_next;      // list being sorted: 0 A, 1 B
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [CNT_W-1:0]           p_reg, p_next;
    logic [VALUE_BITS-1:0]      key_reg, key_next;
    logic [CNT_W-1:0]           ia_reg, ia_next;
    logic [CNT_W-1:0]           ib_reg, ib_next;
    logic [tpm_pkg::PAIR_W-1:0] pairs_reg, pairs_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tpm_pkg::PAIR_W-1:0] out_count_reg, out_count_next;
    logic                       out_ovf_reg, out_ovf_next;

    // RAM ports
    logic                  we_a, we_b;
    logic [AW-1:0]         waddr_a, waddr_b, raddr_a, raddr_b;
    logic [VALUE_BITS-1:0] wdata_a, wdata_b, rd_a, rd_b;

    logic [IW-1:0]         vin_ext;
    logic [VALUE_BITS-1:0] vin;
    logic                  item_xfer;
    logic [CNT_W-1:0]      sort_len;
    logic [CNT_W-1:0]      p_m1;
    logic [VALUE_BITS-1:0] rd_sel;
    logic [VALUE_BITS-1:0] diff;
    logic                  in_tol;
    logic                  sort_we;
    logic [AW-1:0]         sort_waddr, sort_raddr;
    logic [VALUE_BITS-1:0] sort_wdata;

    tpm_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS)) u_ram_a (
        .clk(clk), .we(we_a), .waddr(waddr_a), .wdata(wdata_a),
        .raddr(raddr_a), .rdata(rd_a)
    );

    tpm_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS)) u_ram_b (
        .clk(clk), .we(we_b), .waddr(waddr_b), .wdata(wdata_b),
        .raddr(raddr_b), .rdata(rd_b)
    );

    assign items.ready = (state_reg == S_IDLE);
    assign item_xfer   = items.valid && items.ready;
    assign cfg.ready   = 1'b1;

    assign results.valid      = out_valid_reg;
    assign results.pair_count = out_count_reg;
    assign results.overflow   = out_ovf_reg;

    assign vin_ext  = IW'(items.value);
    assign vin      = vin_ext[VALUE_BITS-1:0];
    assign sort_len = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign p_m1     = p_reg - CNT_ONE;
    assign rd_sel   = sel_reg ? rd_b : rd_a;
    assign diff     = (rd_a > rd_b) ? (rd_a - rd_b) : (rd_b - rd_a);
    assign in_tol   = DW'(diff) <= DW'(tol_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        drop_next      = drop_reg;
        sel_next       = sel_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        key_next       = key_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        pairs_next     = pairs_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        sort_we        = 1'b0;
        sort_waddr     = p_reg[AW-1:0];
        sort_wdata     = key_reg;
        sort_raddr     = k_reg[AW-1:0];
        we_a           = 1'b0;
        we_b           = 1'b0;
        waddr_a        = cnt_a_reg[AW-1:0];
        waddr_b        = cnt_b_reg[AW-1:0];
        wdata_a        = vin;
        wdata_b        = vin;

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    case (items.operation)
                        tpm_pkg::OP_LOAD_A:
                        begin
                            if (cnt_a_reg < CNT_MAX)
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_ONE;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        tpm_pkg::OP_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_MAX)
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_ONE;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        tpm_pkg::OP_COMPUTE:
                        begin
                            sel_next   = 1'b0;
                            k_next     = CNT_ONE;
                            state_next = S_KEY_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_KEY_RD:
            begin
                // next key of the insertion sort, or move on to the next list, or to the walk once both are sorted
                if (k_reg < sort_len)
                begin
                    sort_raddr = k_reg[AW-1:0];
                    state_next = S_KEY_WT;
                end
                else if (!sel_reg)
                begin
                    sel_next = 1'b1;
                    k_next   = CNT_ONE;
                end
                else
                begin
                    ia_next    = '0;
                    ib_next    = '0;
                    pairs_next = '0;
                    state_next = S_M_RD;
                end
            end
            S_KEY_WT:
            begin
                key_next   = rd_sel;
                p_next     = k_reg;
                state_next = S_CMP_RD;
            end
            S_CMP_RD:
            begin
                sort_raddr = p_m1[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                sort_we = 1'b1;
                if (rd_sel > key_reg)
                begin
                    // shift the larger element up one slot
                    sort_wdata = rd_sel;
                    p_next     = p_m1;
                    state_next = (p_m1 == '0) ? S_PUT : S_CMP_RD;
                end
                else
                begin
                    k_next     = k_reg + CNT_ONE;
                    state_next = S_KEY_RD;
                end
            end
            S_PUT:
            begin
                sort_we    = 1'b1;
                k_next     = k_reg + CNT_ONE;
                state_next = S_KEY_RD;
            end
            S_M_RD:
            begin
                if (ia_reg < cnt_a_reg && ib_reg < cnt_b_reg)
                begin
                    state_next = S_M_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_M_CMP:
            begin
                if (in_tol)
                begin
                    if (pairs_reg != '1)
                    begin
                        pairs_next = pairs_reg + 1'b1;
                    end
                    ia_next = ia_reg + CNT_ONE;
                    ib_next = ib_reg + CNT_ONE;
                end
                else if (rd_a < rd_b)
                begin
                    ia_next = ia_reg + CNT_ONE;
                end
                else
                begin
                    ib_next = ib_reg + CNT_ONE;
                end
                state_next = S_M_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = pairs_reg;
                    out_ovf_next   = drop_reg;
                    cnt_a_next     = '0;
                    cnt_b_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // sort traffic goes to the selected list's RAM
        if (sort_we)
        begin
            if (sel_reg)
            begin
                we_b    = 1'b1;
                waddr_b = sort_waddr;
                wdata_b = sort_wdata;
            end
            else
            begin
                we_a    = 1'b1;
                waddr_a = sort_waddr;
                wdata_a = sort_wdata;
            end
        end
    end

    // read addresses: the walk reads both heads, the sort reads one list
    always_comb
    begin
        if (state_reg == S_M_RD || state_reg == S_M_CMP)
        begin
            raddr_a = ia_reg[AW-1:0];
            raddr_b = ib_reg[AW-1:0];
        end
        else
        begin
            raddr_a = sort_raddr;
            raddr_b = sort_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            drop_reg      <= 1'b0;
            tol_reg       <= tpm_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
            if (cfg.valid && cfg.ready)
            begin
                tol_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        p_reg         <= p_next;
        key_reg       <= key_next;
        ia_reg        <= ia_next;
        ib_reg        <= ib_next;
        pairs_reg     <= pairs_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

`include "tolerance_pair_matcher_core_assert.svh"

    `TPM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_a_reg <= CNT_MAX && cnt_b_reg <= CNT_MAX,
                    "list count past capacity")
    `TPM_ASSERT_IMP(a_compute_leaves_idle,
                    item_xfer && items.operation == tpm_pkg::OP_COMPUTE,
                    ##1 state_reg != S_IDLE, "compute did not start")
    `TPM_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE,
                    "result without compute")
    `TPM_ASSERT_IMP(a_walk_bounds, state_reg == S_M_CMP,
                    ia_reg < cnt_a_reg && ib_reg < cnt_b_reg, "walk past list end")

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench: tolerance pair matcher, directed table then random sequences checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int LIST_DEPTH = tpm_pkg::MAX_ITEMS_DEF;
    // Operation code with no function; the block consumes it and does nothing.
    localparam logic [tpm_pkg::OPERATION_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [tpm_pkg::OPERATION_W-1:0] operation;
        logic [tpm_pkg::VALUE_W-1:0]     value;
        logic                            has_expect;
        logic [tpm_pkg::PAIR_W-1:0]      pair_count;
        logic                            overflow;
    } stim_row_t;

    typedef struct packed {
        logic [tpm_pkg::PAIR_W-1:0] pair_count;
        logic                       overflow;
    } match_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tpm_item_if   items();
    tpm_result_if results();
    tpm_cfg_if    cfg();

    tolerance_pair_matcher_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: a shadow copy of both lists, the drop flag and the tolerance.
    logic [tpm_pkg::VALUE_W-1:0] list_a [$];
    logic [tpm_pkg::VALUE_W-1:0] list_b [$];
    logic                        drop_seen;
    logic [tpm_pkg::TOL_W-1:0]   tol_shadow;
    match_result_t               pending_counts [$];
    int                          error_count = 0;
    int                          rows_in_phase;

    // Greedy two-pointer count over sorted copies of the lists.
    function automatic match_result_t count_pairs();
        logic [tpm_pkg::VALUE_W-1:0] sa [$];
        logic [tpm_pkg::VALUE_W-1:0] sb [$];
        int ia;
        int ib;
        int pairs;
        int diff;
        match_result_t r;
        sa = list_a;
        sb = list_b;
        sa.sort();
        sb.sort();
        ia = 0;
        ib = 0;
        pairs = 0;
        while (ia < sa.size() && ib < sb.size())
        begin
            diff = (sa[ia] > sb[ib]) ? sa[ia] - sb[ib] : sb[ib] - sa[ia];
            if (diff <= tol_shadow)
            begin
                pairs++;
                ia++;
                ib++;
            end
            else if (sa[ia] < sb[ib])
                ia++;
            else
                ib++;
        end
        r.pair_count = (pairs > 255) ? 8'd255 : pairs[tpm_pkg::PAIR_W-1:0];
        r.overflow = drop_seen;
        return r;
    endfunction

    // Update the shadow on an accepted transfer; queue the expected result on compute.
    task automatic predict_item(input logic [tpm_pkg::OPERATION_W-1:0] op,
                                input logic [tpm_pkg::VALUE_W-1:0] v);
        if (op == tpm_pkg::OP_LOAD_A)
        begin
            if (list_a.size() < LIST_DEPTH)
                list_a.push_back(v);
            else
                drop_seen = 1'b1;
        end
        else if (op == tpm_pkg::OP_LOAD_B)
        begin
            if (list_b.size() < LIST_DEPTH)
                list_b.push_back(v);
            else
                drop_seen = 1'b1;
        end
        else if (op == tpm_pkg::OP_COMPUTE)
        begin
            pending_counts.push_back(count_pairs());
            list_a.delete();
            list_b.delete();
            drop_seen = 1'b0;
        end
    endtask

    // Random gap: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one transfer; the typed expectation, if any, is checked against the predictor.
    // Valid stays high across back-to-back transfers and drops only for a gap.
    task automatic send_item(input logic [tpm_pkg::OPERATION_W-1:0] op,
                             input logic [tpm_pkg::VALUE_W-1:0] v,
                             input logic has_exp, input match_result_t exp_val);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            items.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.operation <= op;
        items.value <= v;
        do @(posedge clk); while (!items.ready);
        predict_item(op, v);
        if (has_exp && op == tpm_pkg::OP_COMPUTE && pending_counts[$] != exp_val)
        begin
            $error("table row: expected %0d/%0b, predictor %0d/%0b", exp_val.pair_count,
                   exp_val.overflow, pending_counts[$].pair_count, pending_counts[$].overflow);
            error_count++;
        end
    endtask

    task automatic drain();
        items.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (40000) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [tpm_pkg::TOL_W-1:0] t);
        cfg.valid <= 1'b1;
        cfg.data <= t;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        tol_shadow = t;
    endtask

    // Result side: random stall, compare every transfer with the oldest expectation.
    initial
    begin
        match_result_t want;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results.valid && results.ready)
            begin
                if (pending_counts.size() == 0)
                begin
                    $error("result with nothing expected: pair_count=%0d overflow=%0b",
                           results.pair_count, results.overflow);
                    error_count++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (results.pair_count !== want.pair_count)
                    begin
                        $error("pair_count expected %0d actual %0d", want.pair_count,
                               results.pair_count);
                        error_count++;
                    end
                    if (results.overflow !== want.overflow)
                    begin
                        $error("overflow expected %0b actual %0b", want.overflow,
                               results.overflow);
                        error_count++;
                    end
                end
            end
            results.ready <= (gap_len() == 0);
        end
    end

    // Directed table: extremes, every operation, op 3, empty lists.
    stim_row_t directed [] = '{
        '{tpm_pkg::OP_COMPUTE, 8'h00, 1'b1, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_A,  8'h00, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_COMPUTE, 8'h00, 1'b1, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_A,  8'h00, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_B,  8'h01, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_A,  8'hff, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_B,  8'hfe, 1'b0, 8'd0, 1'b0},
        '{OP_IGNORED,          8'haa, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_COMPUTE, 8'h55, 1'b1, 8'd2, 1'b0},
        '{tpm_pkg::OP_LOAD_A,  8'h10, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_B,  8'h12, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_B,  8'h11, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_A,  8'h13, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_COMPUTE, 8'h00, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_LOAD_B,  8'h80, 1'b0, 8'd0, 1'b0},
        '{tpm_pkg::OP_COMPUTE, 8'h00, 1'b1, 8'd0, 1'b0}
    };

    initial
    begin
        int i;
        int n;
        int fill;
        logic [1:0] op;
        logic [tpm_pkg::TOL_W-1:0] tols [5];
        match_result_t exp_val;
        tols = '{8'd0, 8'd255, 8'd3, 8'd17, 8'd1};
        items.valid = 1'b0;
        items.operation = tpm_pkg::OP_LOAD_A;
        items.value = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        drop_seen = 1'b0;
        tol_shadow = tpm_pkg::TOL_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            exp_val.pair_count = directed[k].pair_count;
            exp_val.overflow = directed[k].overflow;
            send_item(directed[k].operation, directed[k].value, directed[k].has_expect,
                      exp_val);
        end
        // Fill list A past capacity to hit the drop path.
        exp_val = '0;
        for (i = 0; i < LIST_DEPTH + 2; i++)
            send_item(tpm_pkg::OP_LOAD_A, i[7:0], 1'b0, exp_val);
        send_item(tpm_pkg::OP_COMPUTE, 8'h00, 1'b1, '{8'd0, 1'b1});
        drain();

        // Random phases, one per tolerance setting; each phase is sequences of loads + compute.
        n = 0;
        foreach (tols[t])
        begin
            write_tolerance(tols[t]);
            rows_in_phase = 0;
            while (rows_in_phase < 80)
            begin
                fill = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 140)
                                                    : $urandom_range(0, 12);
                for (i = 0; i < fill; i++)
                begin
                    op = ($urandom_range(0, 29) == 0) ? OP_IGNORED
                                                      : 2'($urandom_range(0, 1));
                    send_item(op, 8'($urandom), 1'b0, exp_val);
                    rows_in_phase++;
                end
                send_item(tpm_pkg::OP_COMPUTE, 8'($urandom), 1'b0, exp_val);
                rows_in_phase++;
                n++;
                if (n == 7)
                begin
                    // Hold the sender until every result has come back.
                    items.valid <= 1'b0;
                    while (pending_counts.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

>>> tolerance_pair_matcher_core.f
+incdir+sv
sv/tpm_pkg.sv
sv/tpm_if.sv
sv/tpm_ram.sv
sv/tolerance_pair_matcher_core.sv
sim/testbench.sv
